// ===== rtl/whb_pkg.sv =====
package whb_pkg;

    // Store geometry
    localparam int NUM_BINS  = 1024;
    localparam int BIN_AW    = $clog2(NUM_BINS);
    localparam int NB_W      = $clog2(NUM_BINS) + 1;

    // Field widths
    localparam int CMD_W        = 2;
    localparam int SAMPLE_W     = 32;
    localparam int WEIGHT_W     = 16;
    localparam int SEL_W        = 10;
    localparam int BIN_W        = 48;
    localparam int STATUS_W     = 2;
    localparam int CNT_W        = 32;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int BINS_USED_W  = 11;

    // Bin index arithmetic
    localparam int PROD_W    = SAMPLE_W + NB_W;
    localparam int DIV_CNT_W = $clog2(NB_W);

    // Commands
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Fill status codes
    localparam logic [STATUS_W-1:0] ST_IN_RANGE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FILL = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_USED  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic signed [SAMPLE_W-1:0] sample;
        logic [WEIGHT_W-1:0]        weight;
        logic [SEL_W-1:0]           bin_select;
    } whb_in_t;

    typedef struct packed {
        logic [BIN_W-1:0]    bin_value;
        logic [SEL_W-1:0]    landed_bin;
        logic [STATUS_W-1:0] fill_status;
        logic [CNT_W-1:0]    entry_total;
        logic [CNT_W-1:0]    underflow_total;
        logic [CNT_W-1:0]    overflow_total;
    } whb_out_t;

endpackage

// ===== rtl/whb_ram.sv =====
module whb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/weighted_histogram_binner.sv =====
// One-dimensional histogram with equal-width bins over [range_low, range_high),
// 48-bit saturating bins in a single-port-write RAM and 32-bit saturating entry,
// underflow and overflow counters. Items are handled one at a time: an in-range
// fill goes through a 32x11 multiply, an 11-step restoring divider that produces
// the bin index one quotient bit per cycle, then a RAM read-modify-write; an
// underflow or overflow fill goes straight to the output, a read does one RAM
// read, and a clear sweeps the bin RAM one entry per cycle. After reset the same
// sweep runs before the first word is accepted; configuration writes are taken at
// any time. A finished result sits in an output register, so the next word is
// accepted while the previous result is still stalled.
module weighted_histogram_binner
    import whb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  whb_in_t              item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output whb_out_t             result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLASS = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_ADDR  = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_RDW   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    localparam logic [BIN_W-1:0] BIN_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    // Control state
    logic [3:0]             state_reg, state_next;
    logic [BIN_AW-1:0]      clr_addr_reg, clr_addr_next;
    logic                   clr_emit_reg, clr_emit_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   result_valid_reg, result_valid_next;
    logic [CNT_W-1:0]       entry_cnt_reg, entry_cnt_next;
    logic [CNT_W-1:0]       under_cnt_reg, under_cnt_next;
    logic [CNT_W-1:0]       over_cnt_reg, over_cnt_next;
    logic signed [CFG_W-1:0] range_low_reg, range_low_next;
    logic signed [CFG_W-1:0] range_high_reg, range_high_next;
    logic [BINS_USED_W-1:0] bins_used_reg, bins_used_next;

    // Datapath
    whb_in_t                item_reg, item_next;
    logic [SAMPLE_W-1:0]    off_reg, off_next;
    logic [SAMPLE_W-1:0]    span_reg, span_next;
    logic [NB_W-1:0]        nb_reg, nb_next;
    logic [SAMPLE_W-1:0]    rem_reg, rem_next;
    logic [NB_W-1:0]        dq_reg, dq_next;
    logic [BIN_AW-1:0]      idx_reg, idx_next;
    logic                   sel_ok_reg, sel_ok_next;
    whb_out_t               res_reg, res_next;
    whb_out_t               result_reg, result_next;

    logic [PROD_W-1:0]      prod;
    logic [SAMPLE_W:0]      trial;
    logic                   trial_ge;
    logic [NB_W-1:0]        idx_clamped;
    logic [BIN_W:0]         bin_sum;

    // Bin RAM ports
    logic                   ram_we;
    logic [BIN_AW-1:0]      ram_waddr;
    logic [BIN_W-1:0]       ram_wdata;
    logic                   ram_re;
    logic [BIN_AW-1:0]      ram_raddr;
    logic [BIN_W-1:0]       ram_rdata;

    whb_ram #(
        .WIDTH (BIN_W),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Arithmetic helpers
    assign prod        = PROD_W'(off_reg) * PROD_W'(nb_reg);
    assign trial       = {rem_reg, dq_reg[NB_W-1]};
    assign trial_ge    = trial >= {1'b0, span_reg};
    assign idx_clamped = (dq_reg >= nb_reg) ? nb_reg - NB_W'(1) : dq_reg;
    assign bin_sum     = {1'b0, ram_rdata} + (BIN_W+1)'(item_reg.weight);

    // Next-state logic
    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        clr_emit_next     = clr_emit_reg;
        div_cnt_next      = div_cnt_reg;
        result_valid_next = result_valid_reg;
        entry_cnt_next    = entry_cnt_reg;
        under_cnt_next    = under_cnt_reg;
        over_cnt_next     = over_cnt_reg;
        range_low_next    = range_low_reg;
        range_high_next   = range_high_reg;
        bins_used_next    = bins_used_reg;
        item_next         = item_reg;
        off_next          = off_reg;
        span_next         = span_reg;
        nb_next           = nb_reg;
        rem_next          = rem_reg;
        dq_next           = dq_reg;
        idx_next          = idx_reg;
        sel_ok_next       = sel_ok_reg;
        res_next          = res_reg;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = clr_addr_reg;
        ram_wdata         = '0;
        ram_re            = 1'b0;
        ram_raddr         = idx_clamped[BIN_AW-1:0];

        // Configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                REG_RANGE_LOW:  range_low_next  = cfg_data;
                REG_RANGE_HIGH: range_high_next = cfg_data;
                REG_BINS_USED:  bins_used_next  = cfg_data[BINS_USED_W-1:0];
                default: ;
            endcase
        end

        // Output register drains when taken
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + BIN_AW'(1);
                if (clr_addr_reg == BIN_AW'(NUM_BINS - 1))
                begin
                    state_next = clr_emit_reg ? S_EMIT : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_CLASS;
                end
            end

            S_CLASS:
            begin
                res_next.bin_value   = '0;
                res_next.landed_bin  = '0;
                res_next.fill_status = ST_NOT_FILL;
                case (item_reg.command)
                    CMD_FILL:
                    begin
                        if (item_reg.sample < range_low_reg)
                        begin
                            under_cnt_next       = sat_inc(under_cnt_reg);
                            res_next.fill_status = ST_UNDER;
                            state_next           = S_EMIT;
                        end
                        else if (item_reg.sample >= range_high_reg)
                        begin
                            over_cnt_next        = sat_inc(over_cnt_reg);
                            res_next.fill_status = ST_OVER;
                            state_next           = S_EMIT;
                        end
                        else
                        begin
                            off_next  = SAMPLE_W'(item_reg.sample - range_low_reg);
                            span_next = SAMPLE_W'(range_high_reg - range_low_reg);
                            if (bins_used_reg == '0)
                            begin
                                nb_next = NB_W'(1);
                            end
                            else if (bins_used_reg > BINS_USED_W'(NUM_BINS))
                            begin
                                nb_next = NB_W'(NUM_BINS);
                            end
                            else
                            begin
                                nb_next = NB_W'(bins_used_reg);
                            end
                            state_next = S_MUL;
                        end
                    end
                    CMD_READ:
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = BIN_AW'(item_reg.bin_select);
                        sel_ok_next = int'(item_reg.bin_select) < NUM_BINS;
                        state_next  = S_RDW;
                    end
                    CMD_CLEAR:
                    begin
                        entry_cnt_next = '0;
                        under_cnt_next = '0;
                        over_cnt_next  = '0;
                        clr_addr_next  = '0;
                        clr_emit_next  = 1'b1;
                        state_next     = S_CLR;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            // Quotient is below nb, so the top bits of the product seed the remainder
            S_MUL:
            begin
                rem_next     = prod[PROD_W-1:NB_W];
                dq_next      = prod[NB_W-1:0];
                div_cnt_next = '0;
                state_next   = S_DIV;
            end

            // One restoring step per cycle
            S_DIV:
            begin
                rem_next     = trial_ge ? SAMPLE_W'(trial - {1'b0, span_reg})
                                        : trial[SAMPLE_W-1:0];
                dq_next      = {dq_reg[NB_W-2:0], trial_ge};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(NB_W - 1))
                begin
                    state_next = S_ADDR;
                end
            end

            S_ADDR:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_clamped[BIN_AW-1:0];
                idx_next   = idx_clamped[BIN_AW-1:0];
                state_next = S_UPD;
            end

            // Read-modify-write; the next item waits, so no forwarding is needed
            S_UPD:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = bin_sum[BIN_W] ? BIN_MAX : bin_sum[BIN_W-1:0];
                entry_cnt_next       = sat_inc(entry_cnt_reg);
                res_next.bin_value   = ram_wdata;
                res_next.landed_bin  = SEL_W'(idx_reg);
                res_next.fill_status = ST_IN_RANGE;
                state_next           = S_EMIT;
            end

            S_RDW:
            begin
                res_next.bin_value = sel_ok_reg ? ram_rdata : '0;
                state_next         = S_EMIT;
            end

            S_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next                 = res_reg;
                    result_next.entry_total     = entry_cnt_reg;
                    result_next.underflow_total = under_cnt_reg;
                    result_next.overflow_total  = over_cnt_reg;
                    result_valid_next           = 1'b1;
                    clr_emit_next               = 1'b0;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLR;
            clr_addr_reg     <= '0;
            clr_emit_reg     <= 1'b0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
            entry_cnt_reg    <= '0;
            under_cnt_reg    <= '0;
            over_cnt_reg     <= '0;
            range_low_reg    <= CFG_W'(0);
            range_high_reg   <= CFG_W'(1024);
            bins_used_reg    <= BINS_USED_W'(1024);
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            clr_emit_reg     <= clr_emit_next;
            div_cnt_reg      <= div_cnt_next;
            result_valid_reg <= result_valid_next;
            entry_cnt_reg    <= entry_cnt_next;
            under_cnt_reg    <= under_cnt_next;
            over_cnt_reg     <= over_cnt_next;
            range_low_reg    <= range_low_next;
            range_high_reg   <= range_high_next;
            bins_used_reg    <= bins_used_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        off_reg    <= off_next;
        span_reg   <= span_next;
        nb_reg     <= nb_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        idx_reg    <= idx_next;
        sel_ok_reg <= sel_ok_next;
        res_reg    <= res_next;
        result_reg <= result_next;
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/whb_checker.sv =====
module whb_checker
    import whb_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     item_valid,
    input logic     item_stall,
    input logic     result_valid,
    input logic     result_stall,
    input whb_out_t result
);

    // Stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // One word in flight: acceptance closes the input
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second word accepted while one is in work");

    // An in-range fill has been counted
    a_entry_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.fill_status == ST_IN_RANGE |-> result.entry_total != '0)
        else $error("in-range fill with zero entry total");

    // An underflow has been counted
    a_under_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.fill_status == ST_UNDER |-> result.underflow_total != '0)
        else $error("underflow with zero underflow total");

    // Only in-range fills name a bin
    a_landed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.fill_status != ST_IN_RANGE |-> result.landed_bin == '0)
        else $error("landed bin set on a word that is not an in-range fill");

endmodule

bind weighted_histogram_binner whb_checker u_whb_checker (.*);

// ===== tb/weighted_histogram_binner_test.sv =====
module weighted_histogram_binner_test;
    timeunit 1ns;
    timeprecision 1ps;

    import whb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;   // unused code, answers with counters only
    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 240;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_SHOWN = 10;
    localparam longint SAMPLE_MIN = -64'sd2147483648;
    localparam longint SAMPLE_MAX = 64'sd2147483647;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic item_valid = 1'b0;
    logic item_stall;
    whb_in_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    whb_out_t result;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // shadow of the block: configuration, bins, counters
    logic signed [CFG_W-1:0] cfg_low = 32'sd0;
    logic signed [CFG_W-1:0] cfg_high = 32'sd1024;
    logic [BINS_USED_W-1:0] cfg_bins = 11'd1024;
    logic [BIN_W-1:0] bin_tally [NUM_BINS];
    logic [CNT_W-1:0] entry_tally = '0;
    logic [CNT_W-1:0] under_tally = '0;
    logic [CNT_W-1:0] over_tally = '0;

    whb_in_t queued_words [$];
    whb_out_t due_results [$];

    int mismatch_count = 0;
    bit sender_idle_on = 1'b1;
    bit receiver_idle_on = 1'b1;
    int hold_asked = 0;

    weighted_histogram_binner uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Apply one word to the shadow histogram and return the result it produces
    function automatic whb_out_t histogram_apply(whb_in_t w);
        whb_out_t r;
        longint s, lo, hi, nb, idx;
        logic [BIN_W:0] sum;
        r = '0;
        r.fill_status = ST_NOT_FILL;
        case (w.command)
            CMD_FILL:
            begin
                s = longint'($signed(w.sample));
                lo = longint'(cfg_low);
                hi = longint'(cfg_high);
                if (s < lo)
                begin
                    under_tally = bump(under_tally);
                    r.fill_status = ST_UNDER;
                end
                else if (s >= hi)
                begin
                    over_tally = bump(over_tally);
                    r.fill_status = ST_OVER;
                end
                else
                begin
                    nb = longint'(cfg_bins);
                    if (nb == 0)
                        nb = 1;
                    if (nb > NUM_BINS)
                        nb = NUM_BINS;
                    idx = (s - lo) * nb / (hi - lo);
                    if (idx >= nb)
                        idx = nb - 1;
                    sum = {1'b0, bin_tally[idx]} + {{(BIN_W + 1 - WEIGHT_W){1'b0}}, w.weight};
                    bin_tally[idx] = sum[BIN_W] ? BIN_MAX : sum[BIN_W-1:0];
                    entry_tally = bump(entry_tally);
                    r.bin_value = bin_tally[idx];
                    r.landed_bin = idx[SEL_W-1:0];
                    r.fill_status = ST_IN_RANGE;
                end
            end
            CMD_READ:
                r.bin_value = bin_tally[w.bin_select];
            CMD_CLEAR:
            begin
                foreach (bin_tally[i])
                    bin_tally[i] = '0;
                entry_tally = '0;
                under_tally = '0;
                over_tally = '0;
            end
            default: ;
        endcase
        r.entry_total = entry_tally;
        r.underflow_total = under_tally;
        r.overflow_total = over_tally;
        return r;
    endfunction

    // Sample biased toward the current range and its edges
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        longint lo, hi, width, v;
        int sel;
        lo = longint'(cfg_low);
        hi = longint'(cfg_high);
        sel = $urandom_range(0, 19);
        case (sel)
            0, 1: v = longint'($signed($urandom()));
            2: v = lo;
            3: v = hi;
            4: v = hi - 1;
            5: v = lo - 1;
            default:
            begin
                width = (hi > lo) ? hi - lo : 64;
                width = width + width / 4 + 2;
                v = lo - width / 8 - 1 + (longint'({$urandom(), $urandom()} >> 1) % width);
            end
        endcase
        if (v < SAMPLE_MIN)
            v = SAMPLE_MIN;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic whb_in_t make_word();
        whb_in_t w;
        int pick, nb;
        pick = $urandom_range(0, 99);
        if (pick < 74)
            w.command = CMD_FILL;
        else if (pick < 94)
            w.command = CMD_READ;
        else if (pick < 97)
            w.command = CMD_NOP;
        else
            w.command = CMD_CLEAR;
        w.sample = pick_sample();
        pick = $urandom_range(0, 9);
        if (pick == 0)
            w.weight = '0;
        else if (pick == 1)
            w.weight = '1;
        else
            w.weight = WEIGHT_W'($urandom_range(0, 65535));
        nb = int'(cfg_bins);
        if (nb == 0)
            nb = 1;
        if (nb > NUM_BINS)
            nb = NUM_BINS;
        if ($urandom_range(0, 9) < 7)
            w.bin_select = SEL_W'($urandom_range(0, nb - 1));
        else
            w.bin_select = SEL_W'($urandom_range(0, NUM_BINS - 1));
        return w;
    endfunction

    function automatic void queue_word(logic [CMD_W-1:0] c, logic [SAMPLE_W-1:0] s,
                                       logic [WEIGHT_W-1:0] wt, logic [SEL_W-1:0] sel);
        whb_in_t w;
        w.command = c;
        w.sample = s;
        w.weight = wt;
        w.bin_select = sel;
        queued_words.push_back(w);
    endfunction

    // Sender: present queued words, random gaps between them
    int gap_left = 0;
    always @(posedge clk)
    begin : drive_items
        logic nv;
        whb_in_t nw;
        nv = item_valid;
        nw = item;
        if (!rst_n)
        begin
            nv = 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                due_results.push_back(histogram_apply(item));
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (queued_words.size() != 0)
                begin
                    if (sender_idle_on && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 6) - 1;
                    else
                    begin
                        nw = queued_words.pop_front();
                        nv = 1'b1;
                    end
                end
            end
        end
        item_valid <= nv;
        item <= nw;
    end

    // Receiver: check each word taken, stall in bursts or for a long hold when one is asked
    int stall_left = 0;
    int hold_left = 0;
    int hold_done = 0;
    always @(posedge clk)
    begin : take_results
        logic ns;
        whb_out_t want;
        ns = 1'b0;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("unexpected result word: bin=%0d landed=%0d status=%0d",
                                 result.bin_value, result.landed_bin, result.fill_status);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.bin_value !== want.bin_value
                        || result.landed_bin !== want.landed_bin
                        || result.fill_status !== want.fill_status
                        || result.entry_total !== want.entry_total
                        || result.underflow_total !== want.underflow_total
                        || result.overflow_total !== want.overflow_total)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_SHOWN)
                        begin
                            $display("mismatch at %0t: expected bin=%0d landed=%0d status=%0d",
                                     $realtime, want.bin_value, want.landed_bin,
                                     want.fill_status);
                            $display("    entries=%0d under=%0d over=%0d",
                                     want.entry_total, want.underflow_total,
                                     want.overflow_total);
                            $display("  got bin=%0d landed=%0d status=%0d",
                                     result.bin_value, result.landed_bin, result.fill_status);
                            $display("    entries=%0d under=%0d over=%0d",
                                     result.entry_total, result.underflow_total,
                                     result.overflow_total);
                        end
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ns = 1'b1;
            end
            else if (hold_done != hold_asked)
            begin
                hold_left = HOLD_CYCLES - 1;
                hold_done++;
                ns = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                ns = 1'b1;
            end
            else if (receiver_idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                ns = 1'b1;
            end
        end
        result_stall <= ns;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    // Load all three registers; the bin count carries junk above its width
    task automatic load_setup(logic signed [CFG_W-1:0] lo, logic signed [CFG_W-1:0] hi,
                              logic [BINS_USED_W-1:0] nb);
        write_reg(REG_RANGE_LOW, lo);
        write_reg(REG_RANGE_HIGH, hi);
        write_reg(REG_BINS_USED, {(CFG_W - BINS_USED_W)'($urandom()), nb});
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_low = lo;
        cfg_high = hi;
        cfg_bins = nb;
    endtask

    // Wait until every queued word has been answered, then let the block settle
    task automatic drain();
        while (queued_words.size() != 0 || item_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Phase settings: narrow, full span, empty, reversed, tiny span, bottom edge, random, shifted
    logic signed [CFG_W-1:0] phase_low [PHASES] = '{
        -32'sd1000, -32'sd2147483648, 32'sd100, 32'sd500,
        32'sd0, -32'sd2147483648, 32'sd0, 32'sd7};
    logic signed [CFG_W-1:0] phase_high [PHASES] = '{
        32'sd1000, 32'sd2147483647, 32'sd100, -32'sd500,
        32'sd3, -32'sd2147483000, 32'sd0, 32'sd1031};
    logic [BINS_USED_W-1:0] phase_bins [PHASES] = '{
        11'd7, 11'd1024, 11'd1, 11'd0, 11'd2047, 11'd1000, 11'd1, 11'd1024};

    initial
    begin : run_phases
        logic signed [CFG_W-1:0] lo, hi;
        logic [BINS_USED_W-1:0] nb;
        foreach (bin_tally[i])
            bin_tally[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset setup: bin index equals sample
        queue_word(CMD_FILL, 32'd0, 16'hFFFF, 10'd0);
        queue_word(CMD_FILL, 32'd0, 16'hFFFF, 10'h3FF);
        queue_word(CMD_FILL, 32'd1023, 16'd1, 10'd0);
        queue_word(CMD_FILL, 32'd1024, 16'd5, 10'd0);            // upper bound is overflow
        queue_word(CMD_FILL, 32'hFFFF_FFFF, 16'd9, 10'd0);       // just below lower bound
        queue_word(CMD_FILL, 32'h8000_0000, 16'hFFFF, 10'h3FF);
        queue_word(CMD_FILL, 32'h7FFF_FFFF, 16'hFFFF, 10'h3FF);
        queue_word(CMD_FILL, 32'd512, 16'd0, 10'd0);             // zero weight
        queue_word(CMD_FILL, 32'd1, 16'h5555, 10'd0);
        queue_word(CMD_READ, 32'h7FFF_FFFF, 16'hFFFF, 10'd0);
        queue_word(CMD_READ, 32'd0, 16'd0, 10'd1023);
        queue_word(CMD_READ, 32'd0, 16'd0, 10'd512);
        queue_word(CMD_READ, 32'd0, 16'd0, 10'd1);
        queue_word(CMD_READ, 32'd0, 16'd0, 10'd700);             // never written
        queue_word(CMD_NOP, 32'hA5A5_5A5A, 16'hFFFF, 10'h3FF);
        queue_word(CMD_CLEAR, 32'd3, 16'd3, 10'd3);
        queue_word(CMD_READ, 32'd0, 16'd0, 10'd0);               // cleared bin
        queue_word(CMD_FILL, 32'd5, 16'hAAAA, 10'd0);
        queue_word(CMD_READ, 32'd5, 16'd0, 10'd5);
        queue_word(CMD_FILL, 32'd5, 16'h5555, 10'd5);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            lo = phase_low[p];
            hi = phase_high[p];
            nb = phase_bins[p];
            if (p == 6)
            begin
                lo = 32'($signed($urandom_range(0, 2097152)) - 1048576);
                hi = lo + $signed($urandom_range(1, 5000));
                nb = BINS_USED_W'($urandom_range(1, NUM_BINS));
            end
            load_setup(lo, hi, nb);
            sender_idle_on = (p % 3 != 2) && (p != PHASES - 1);
            receiver_idle_on = (p % 3 != 1) && (p != PHASES - 1);
            if (p == 1 || p == 4)
                hold_asked++;
            for (int k = 0; k < WORDS_PER_PHASE; k++)
                queued_words.push_back(make_word());
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("weighted_histogram_binner_test: done, clean");
        else
            $display("weighted_histogram_binner_test: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("weighted_histogram_binner_test: done, errors");
        $finish;
    end

endmodule
